FILE: hw/rtl/pes_pkg.sv
// shared types and constants of the periodic event scheduler
package pes_pkg;

  localparam int unsigned ID_W    = 16;
  localparam int unsigned PER_W   = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned ENTRY_W = TIME_W + ID_W + PER_W;

  localparam logic MODE_REGISTER = 1'b0;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    status_e             status;
    logic [ID_W-1:0]     fired_id;
    logic [TIME_W-1:0]   fire_time;
  } result_t;

  typedef logic [ENTRY_W-1:0] entry_t;

endpackage

FILE: hw/rtl/pes_ram.sv
// generic single-port-write, single-port-read ram with registered read
module pes_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/pes_heap_seq.sv
// heap sequencer: sift-up on register, pop-advance-sift-down on next
module pes_heap_seq #(
  parameter int unsigned MAX_QUERIES = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       mode_i,
  input  logic [pes_pkg::ID_W-1:0]   query_id_i,
  input  logic [pes_pkg::PER_W-1:0]  period_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output pes_pkg::result_t           res_o
);

  localparam int unsigned AW = (MAX_QUERIES > 1) ? $clog2(MAX_QUERIES) : 1;
  localparam int unsigned CW = $clog2(MAX_QUERIES + 1);
  localparam int unsigned IW = AW + 2;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_UP_RD  = 4'd1;
  localparam logic [3:0] ST_UP_CMP = 4'd2;
  localparam logic [3:0] ST_TOP    = 4'd3;
  localparam logic [3:0] ST_DN_RD0 = 4'd4;
  localparam logic [3:0] ST_DN_RD1 = 4'd5;
  localparam logic [3:0] ST_DN_CMP = 4'd6;
  localparam logic [3:0] ST_EMIT   = 4'd7;

  logic [3:0]             state_q, state_d;
  logic [CW-1:0]          count_q, count_d;
  logic [AW-1:0]          pos_q, pos_d;
  logic [AW-1:0]          link_q, link_d;
  logic                   has_r_q, has_r_d;
  pes_pkg::entry_t        e_q, e_d;
  pes_pkg::entry_t        d0_q, d0_d;
  pes_pkg::result_t       res_q, res_d;

  logic                   we;
  logic [AW-1:0]          waddr;
  pes_pkg::entry_t        wdata;
  logic                   re;
  logic [AW-1:0]          raddr;
  pes_pkg::entry_t        rdata;

  logic                   accept;
  logic [IW-1:0]          child;
  logic [IW-1:0]          child_r;
  logic [IW-1:0]          count_x;
  logic [pes_pkg::TIME_W:0] sum;
  logic [pes_pkg::TIME_W-1:0] next_time;
  logic                   pick_r;
  logic                   d0_ge;
  logic                   d1_ge;

  pes_ram #(
    .Width (pes_pkg::ENTRY_W),
    .Depth (MAX_QUERIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign accept    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_EMIT);
  assign res_o     = res_q;

  assign child     = {1'b0, pos_q, 1'b1};
  assign child_r   = child + IW'(1);
  assign count_x   = IW'(count_q);
  assign sum       = {1'b0, rdata[pes_pkg::ENTRY_W-1 -: pes_pkg::TIME_W]}
                   + (pes_pkg::TIME_W + 1)'(rdata[pes_pkg::PER_W-1:0]);
  assign next_time = sum[pes_pkg::TIME_W] ? '1 : sum[pes_pkg::TIME_W-1:0];

  assign pick_r = has_r_q && (rdata < d0_q);
  assign d0_ge  = (d0_q >= e_q);
  assign d1_ge  = (rdata >= e_q);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    pos_d   = pos_q;
    link_d  = link_q;
    has_r_d = has_r_q;
    e_d     = e_q;
    d0_d    = d0_q;
    res_d   = res_q;
    we      = 1'b0;
    waddr   = pos_q;
    wdata   = e_q;
    re      = 1'b0;
    raddr   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_d = '{status: pes_pkg::STATUS_OK, fired_id: '0, fire_time: '0};
          if (mode_i == pes_pkg::MODE_REGISTER) begin
            if (count_q == CW'(MAX_QUERIES)) begin
              res_d.status = pes_pkg::STATUS_FULL;
              state_d      = ST_EMIT;
            end else begin
              e_d     = {pes_pkg::TIME_W'(period_i), query_id_i, period_i};
              pos_d   = count_q[AW-1:0];
              count_d = count_q + CW'(1);
              state_d = ST_UP_RD;
            end
          end else if (count_q == '0) begin
            res_d.status = pes_pkg::STATUS_EMPTY;
            state_d      = ST_EMIT;
          end else begin
            re      = 1'b1;
            state_d = ST_TOP;
          end
        end
      end
      ST_UP_RD: begin
        if (pos_q == '0) begin
          we      = 1'b1;
          state_d = ST_EMIT;
        end else begin
          re      = 1'b1;
          raddr   = (pos_q - AW'(1)) >> 1;
          link_d  = raddr;
          state_d = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        we = 1'b1;
        if (rdata <= e_q) begin
          state_d = ST_EMIT;
        end else begin
          wdata   = rdata;
          pos_d   = link_q;
          state_d = ST_UP_RD;
        end
      end
      ST_TOP: begin
        res_d.fired_id  = rdata[pes_pkg::PER_W +: pes_pkg::ID_W];
        res_d.fire_time = rdata[pes_pkg::ENTRY_W-1 -: pes_pkg::TIME_W];
        e_d   = {next_time, rdata[pes_pkg::PER_W +: pes_pkg::ID_W],
                 rdata[pes_pkg::PER_W-1:0]};
        pos_d   = '0;
        state_d = ST_DN_RD0;
      end
      ST_DN_RD0: begin
        if (child >= count_x) begin
          we      = 1'b1;
          state_d = ST_EMIT;
        end else begin
          re      = 1'b1;
          raddr   = child[AW-1:0];
          link_d  = child[AW-1:0];
          has_r_d = (child_r < count_x);
          state_d = ST_DN_RD1;
        end
      end
      ST_DN_RD1: begin
        d0_d    = rdata;
        re      = has_r_q;
        raddr   = link_q + AW'(1);
        state_d = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        we = 1'b1;
        if (pick_r ? d1_ge : d0_ge) begin
          state_d = ST_EMIT;
        end else begin
          wdata   = pick_r ? rdata : d0_q;
          pos_d   = pick_r ? (link_q + AW'(1)) : link_q;
          state_d = ST_DN_RD0;
        end
      end
      ST_EMIT: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    link_q  <= link_d;
    has_r_q <= has_r_d;
    e_q     <= e_d;
    d0_q    <= d0_d;
    res_q   <= res_d;
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_QUERIES))
    else $error("entry count above capacity");

  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(count_q))
    else $error("entry count changed outside an accepted word");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (IW'(waddr) < count_x))
    else $error("heap write beyond valid entries");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (re && state_q != ST_IDLE) |-> (IW'(raddr) < count_x))
    else $error("heap read beyond valid entries");
`endif

endmodule

FILE: hw/rtl/pes_out_reg.sv
// output register between the sequencer and the result stream
module pes_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pes_pkg::result_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output pes_pkg::result_t out_data_o
);

  logic             valid_q, valid_d;
  pes_pkg::result_t data_q;

  assign in_ready_o = !valid_q || out_ready_i;
  assign valid_d    = (in_valid_i && in_ready_o) || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

FILE: hw/rtl/periodic_event_scheduler_core.sv
// periodic event scheduler top level
// Keeps up to MAX_QUERIES periodic queries in a binary min-heap held in one
// ram with one write and one registered read port. A register word does
// one parent read and compare per level of sift-up; a next word does up to
// two child reads and a compare per level of sift-down. Full and empty
// cases return a status without touching the ram.
// One word is processed at a time; a finished result waits in an output
// register while the next word is accepted. No clearing pass is needed
// after reset.
module periodic_event_scheduler_core #(
  parameter int unsigned MAX_QUERIES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // query_id[15:0], period[31:16]
  input  logic [0:0]  s_axis_tuser_i,  // mode[0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,  // fired_id[15:0], fire_time[47:16]
  output logic [1:0]  m_axis_tuser_o   // status[1:0]
);

  logic             res_valid;
  logic             res_ready;
  pes_pkg::result_t res;
  pes_pkg::result_t out;

  pes_heap_seq #(
    .MAX_QUERIES (MAX_QUERIES)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .mode_i      (s_axis_tuser_i[0]),
    .query_id_i  (s_axis_tdata_i[15:0]),
    .period_i    (s_axis_tdata_i[31:16]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  pes_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_ready_o  (res_ready),
    .in_data_i   (res),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (out)
  );

  assign m_axis_tdata_o = {out.fire_time, out.fired_id};
  assign m_axis_tuser_o = out.status;

endmodule
